// ===== rtl/core/ssha_pkg.sv =====
`timescale 1ns / 1ps

package ssha_pkg;

  localparam int MAX_IDS = 16;
  localparam int ID_W    = $clog2(MAX_IDS);
  localparam int CNT_W   = $clog2(MAX_IDS + 1);
  localparam int MASK_W  = 64;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;

  typedef struct packed {
    logic  operation;
    id_t   entity_id;
    mask_t component_mask;
  } ssha_in_t;

  typedef struct packed {
    logic [1:0] status;
    id_t        assigned_id;
    id_t        dense_slot;
    cnt_t       live_count;
  } ssha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_EDGE,
    ST_A_WR_HEAD,
    ST_A_FIN,
    ST_F_MOVE,
    ST_F_SCAN,
    ST_F_WR_POS,
    ST_F_FIN
  } ssha_state_t;

endpackage

// ===== rtl/core/sparse_set_handle_allocator.sv =====
`timescale 1ns / 1ps

// Allocate: ST_A_EDGE, ST_A_WR_HEAD, ST_A_FIN, then the registered strobe; busy until it shows.
// Free: ST_F_MOVE, ST_F_SCAN, ST_F_WR_POS, ST_F_FIN, then the strobe; in ST_F_SCAN the
// single read port of the free-ID memory scans the used partition entry by entry for the ID.
// Table full / entity not live: strobe in the cycle right after accept.
// A new beat may be started in the cycle the strobe shows; the receiver cannot stall.
// Synchronous active-low reset: empty table, identity free list, no clearing pass.
module sparse_set_handle_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ssha_pkg::ssha_in_t  in_item,
  output logic                out_valid,
  output ssha_pkg::ssha_out_t out_item
);
  import ssha_pkg::*;

  // memories
  id_t   free_mem [MAX_IDS];
  id_t   s2i_mem  [MAX_IDS];
  id_t   i2s_mem  [MAX_IDS];
  mask_t mask_mem [MAX_IDS];

  ssha_state_t state_r, state_nxt;
  cnt_t        live_r, live_nxt;
  logic [MAX_IDS-1:0] id_valid_r, id_valid_nxt;
  logic [MAX_IDS-1:0] fv_r, fv_nxt;   // free_mem entry written since reset
  logic        out_valid_r, out_valid_nxt;
  ssha_out_t   out_r, out_nxt;

  id_t   eid_r, eid_nxt;
  mask_t mask_r, mask_nxt;
  id_t   id_r, id_nxt;
  id_t   edge_r, edge_nxt;
  id_t   pos_r, pos_nxt;
  id_t   hole_r, hole_nxt;
  id_t   scan_r, scan_nxt;

  // memory ports
  logic  free_re, free_we;
  id_t   free_ra, free_wa, free_wd;
  id_t   free_ra_r, free_rd_r, free_q;
  logic  slot_re;
  id_t   slot_ra, i2s_ra;
  logic  s2i_we, i2s_we, mask_we;
  id_t   s2i_wa, s2i_wd, i2s_wa, i2s_wd, mask_wa;
  mask_t mask_wd;
  id_t   s2i_rd_r, i2s_rd_r;
  mask_t mask_rd_r;
  cnt_t  free_edge;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // unwritten free-list entries still hold their reset value (the index)
  assign free_q    = fv_r[free_ra_r] ? free_rd_r : free_ra_r;
  assign free_edge = CNT_W'(MAX_IDS) - live_r;

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    id_valid_nxt  = id_valid_r;
    fv_nxt        = fv_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    eid_nxt       = eid_r;
    mask_nxt      = mask_r;
    id_nxt        = id_r;
    edge_nxt      = edge_r;
    pos_nxt       = pos_r;
    hole_nxt      = hole_r;
    scan_nxt      = scan_r;
    free_re = 1'b0;  free_ra = '0;
    free_we = 1'b0;  free_wa = '0;  free_wd = '0;
    slot_re = 1'b0;  slot_ra = '0;  i2s_ra  = '0;
    s2i_we  = 1'b0;  s2i_wa  = '0;  s2i_wd  = '0;
    i2s_we  = 1'b0;  i2s_wa  = '0;  i2s_wd  = '0;
    mask_we = 1'b0;  mask_wa = '0;  mask_wd = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          eid_nxt  = in_item.entity_id;
          mask_nxt = in_item.component_mask;
          if (in_item.operation == OP_ALLOC) begin
            if (live_r == CNT_W'(MAX_IDS)) begin
              out_valid_nxt       = 1'b1;
              out_nxt.status      = STATUS_FULL;
              out_nxt.assigned_id = '0;
              out_nxt.dense_slot  = '0;
              out_nxt.live_count  = live_r;
            end else begin
              free_re   = 1'b1;
              free_ra   = '0;
              state_nxt = ST_A_EDGE;
            end
          end else if (id_valid_r[in_item.entity_id] && live_r != '0) begin
            slot_re   = 1'b1;
            slot_ra   = ID_W'(live_r - CNT_W'(1));
            i2s_ra    = in_item.entity_id;
            state_nxt = ST_F_MOVE;
          end else begin
            out_valid_nxt       = 1'b1;
            out_nxt.status      = STATUS_NOT_LIVE;
            out_nxt.assigned_id = '0;
            out_nxt.dense_slot  = '0;
            out_nxt.live_count  = live_r;
          end
        end
      end

      ST_A_EDGE: begin
        // free_q is the head of the free partition; append it at the dense end
        id_nxt   = free_q;
        edge_nxt = ID_W'(MAX_IDS - 1) - live_r[ID_W-1:0];
        free_re  = 1'b1;
        free_ra  = ID_W'(MAX_IDS - 1) - live_r[ID_W-1:0];
        s2i_we   = 1'b1;
        s2i_wa   = live_r[ID_W-1:0];
        s2i_wd   = free_q;
        mask_we  = 1'b1;
        mask_wa  = live_r[ID_W-1:0];
        mask_wd  = mask_r;
        i2s_we   = 1'b1;
        i2s_wa   = free_q;
        i2s_wd   = live_r[ID_W-1:0];
        id_valid_nxt[free_q] = 1'b1;
        live_nxt  = live_r + CNT_W'(1);
        state_nxt = ST_A_WR_HEAD;
      end

      ST_A_WR_HEAD: begin
        free_we   = 1'b1;
        free_wa   = '0;
        free_wd   = free_q;
        state_nxt = ST_A_FIN;
      end

      ST_A_FIN: begin
        free_we             = 1'b1;
        free_wa             = edge_r;
        free_wd             = id_r;
        out_valid_nxt       = 1'b1;
        out_nxt.status      = STATUS_OK;
        out_nxt.assigned_id = id_r;
        out_nxt.dense_slot  = ID_W'(live_r - CNT_W'(1));
        out_nxt.live_count  = live_r;
        state_nxt           = ST_IDLE;
      end

      ST_F_MOVE: begin
        // last dense entry fills the hole
        hole_nxt = i2s_rd_r;
        s2i_we   = 1'b1;
        s2i_wa   = i2s_rd_r;
        s2i_wd   = s2i_rd_r;
        mask_we  = 1'b1;
        mask_wa  = i2s_rd_r;
        mask_wd  = mask_rd_r;
        i2s_we   = 1'b1;
        i2s_wa   = s2i_rd_r;
        i2s_wd   = i2s_rd_r;
        id_valid_nxt[eid_r] = 1'b0;
        live_nxt  = live_r - CNT_W'(1);
        // scan starts at the head of the used partition
        edge_nxt  = free_edge[ID_W-1:0];
        free_re   = 1'b1;
        free_ra   = free_edge[ID_W-1:0];
        scan_nxt  = free_edge[ID_W-1:0] + ID_W'(1);
        state_nxt = ST_F_SCAN;
      end

      ST_F_SCAN: begin
        free_re = 1'b1;
        if (free_q == eid_r) begin
          pos_nxt   = free_ra_r;
          free_ra   = edge_r;
          state_nxt = ST_F_WR_POS;
        end else begin
          free_ra  = scan_r;
          scan_nxt = scan_r + ID_W'(1);
        end
      end

      ST_F_WR_POS: begin
        free_we   = 1'b1;
        free_wa   = pos_r;
        free_wd   = free_q;
        state_nxt = ST_F_FIN;
      end

      ST_F_FIN: begin
        free_we             = 1'b1;
        free_wa             = edge_r;
        free_wd             = eid_r;
        out_valid_nxt       = 1'b1;
        out_nxt.status      = STATUS_OK;
        out_nxt.assigned_id = '0;
        out_nxt.dense_slot  = hole_r;
        out_nxt.live_count  = live_r;
        state_nxt           = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (free_we) begin
      fv_nxt[free_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      id_valid_r  <= '0;
      fv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      id_valid_r  <= id_valid_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    eid_r  <= eid_nxt;
    mask_r <= mask_nxt;
    id_r   <= id_nxt;
    edge_r <= edge_nxt;
    pos_r  <= pos_nxt;
    hole_r <= hole_nxt;
    scan_r <= scan_nxt;
  end

  always_ff @(posedge clk) begin
    if (free_re) begin
      free_rd_r <= free_mem[free_ra];
      free_ra_r <= free_ra;
    end
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_re) begin
      s2i_rd_r  <= s2i_mem[slot_ra];
      mask_rd_r <= mask_mem[slot_ra];
      i2s_rd_r  <= i2s_mem[i2s_ra];
    end
    if (s2i_we) begin
      s2i_mem[s2i_wa] <= s2i_wd;
    end
    if (mask_we) begin
      mask_mem[mask_wa] <= mask_wd;
    end
    if (i2s_we) begin
      i2s_mem[i2s_wa] <= i2s_wd;
    end
  end

  a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(id_valid_r) == live_r)
    else $error("live count differs from number of live IDs");

  a_strobe_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.live_count == live_r)
    else $error("reported live_count differs from table state");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while an operation is still in progress");

  a_free_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation == OP_FREE && id_valid_r[in_item.entity_id])
      |=> busy && !out_valid)
    else $error("free of a live ID did not start the move sequence");

endmodule
